/* design/qpht_pkg.sv */
// Package: sizes, codes, state encoding and a helper function of the hash table
package qpht_pkg;

    localparam int SLOTS     = 16;
    localparam int HOME_MOD  = 5;
    localparam int KEY_W     = 31;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int HOME_W    = (HOME_MOD > 1) ? $clog2(HOME_MOD) : 1;
    localparam int J_LAST    = SLOTS / 2;
    localparam int J_W       = $clog2(J_LAST + 1);

    // key mod HOME_MOD: q = (key * RECIP) >> RECIP_SH is the exact quotient for any
    // KEY_W-bit key, then key - q * HOME_MOD
    localparam int HOME_SH   = (HOME_MOD > 1) ? $clog2(HOME_MOD) : 0;
    localparam int RECIP_SH  = KEY_W + HOME_SH;
    localparam int RECIP_W   = KEY_W + 1;
    localparam int PROD_W    = KEY_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - RECIP_SH;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SH) + 64'(HOME_MOD) - 64'd1) / 64'(HOME_MOD);

    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [HOME_W-1:0]  t_home;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [RECIP_W-1:0] t_recip;

    localparam t_recip RECIP  = t_recip'(RECIP_VAL);
    localparam t_key   HOME_K = t_key'(HOME_MOD);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOME,
        ST_INS,
        ST_DCHK,
        ST_SRD,
        ST_SCMP,
        ST_CRD,
        ST_CCMP,
        ST_DONE
    } t_state;

    // home value stored next to the key so compaction never recomputes it
    typedef struct packed {
        t_home home;
        t_key  key;
    } t_entry;

    // home mod SLOTS (SLOTS is a power of two)
    function automatic t_slot home_slot(t_home h);
        logic [HOME_W+SLOT_W-1:0] w;
        w = (HOME_W + SLOT_W)'(h);
        return w[SLOT_W-1:0];
    endfunction

endpackage

/* design/qpht_if.sv */
// Interfaces: request (op, key) and response (success) channels
interface qpht_req_if
    import qpht_pkg::*;
();
    logic valid;
    logic ready;
    t_op  op;
    t_key key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface qpht_rsp_if;
    logic valid;
    logic ready;
    logic success;

    modport source (output valid, output success, input ready);
    modport sink   (input valid, input success, output ready);
endinterface

/* design/quadratic_probe_hash_table.sv */
// Top level: open-addressed hash table with quadratic probing and delete compaction
//
//  channel  | dir | word          | handshake
//  ---------+-----+---------------+-------------
//  i_req    | in  | op, key       | valid/ready
//  o_rsp    | out | success       | valid/ready
//
// One word at a time. The key remainder is a reciprocal multiply, then a multiply back
// and subtract; insert then probes one slot a cycle over offsets 0..8; delete checks
// the home slot, then searches and compacts over offsets 0..8, reading each slot and
// then comparing it. The done state hands the word to the output register once it is
// free, and the idle state takes the next one.
// Reset empties every slot at once; the key memory itself is not cleared.
// A stalled output holds the finished word; the next request is taken meanwhile.
module quadratic_probe_hash_table
    import qpht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    qpht_req_if.sink  i_req,
    qpht_rsp_if.source o_rsp
);

    t_state             r_state, n_state;
    logic [SLOTS-1:0]   r_slot_valid;
    t_entry             r_mem [SLOTS];
    t_entry             r_rd_data;

    t_op                r_op;
    t_key               r_key;
    t_home              r_home;
    logic [QUOT_W-1:0]  r_quot;
    logic               r_step;
    logic [J_W-1:0]     r_j;
    t_slot              r_sq;
    t_slot              r_hole;
    logic               r_succ;
    logic               r_out_valid;
    logic               r_out_success;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_last;
    logic               w_step_last;
    logic [PROD_W-1:0]  w_prod;
    t_key               w_qd;
    t_key               w_rem;
    t_slot              w_slot;
    t_slot              w_sq_nx;
    logic [SLOT_W:0]    w_odd;
    logic               w_s_valid;
    logic               w_key_hit;
    logic               w_home_hit;

    logic               w_adv;
    logic               w_mem_we;
    t_slot              w_wr_addr;
    t_entry             w_wdata;
    logic               w_set_en;
    logic               w_clr_en;
    t_slot              w_clr_addr;
    logic               w_hole_ld;
    t_slot              w_hole_nx;
    logic               w_succ_ld;
    logic               w_succ_val;

    assign i_req.ready   = (r_state == ST_IDLE);
    assign w_in_acc      = i_req.valid && i_req.ready;
    assign w_out_free    = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.success = r_out_success;

    assign w_last      = (r_j == J_W'(J_LAST));
    assign w_step_last = r_step;
    // remainder: quotient while r_step is low, key - q * HOME_MOD once it is high
    assign w_prod      = PROD_W'(r_key) * PROD_W'(RECIP);
    assign w_qd        = t_key'(r_quot) * HOME_K;
    assign w_rem       = r_key - w_qd;
    assign w_slot      = home_slot(r_home) + r_sq;
    // (j+1)^2 = j^2 + 2j + 1
    assign w_odd       = {SLOT_W'(r_j), 1'b1};
    assign w_sq_nx     = r_sq + w_odd[SLOT_W-1:0];
    assign w_s_valid   = r_slot_valid[w_slot];
    assign w_key_hit   = w_s_valid && (r_rd_data.key == r_key);
    assign w_home_hit  = w_s_valid && (r_rd_data.home == r_home);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_HOME;
            ST_HOME: begin
                if (w_step_last) n_state = (r_op == OP_INSERT) ? ST_INS : ST_DCHK;
            end
            ST_INS:  if (!w_s_valid || w_last) n_state = ST_DONE;
            ST_DCHK: n_state = w_s_valid ? ST_SRD : ST_DONE;
            ST_SRD:  n_state = ST_SCMP;
            ST_SCMP: begin
                if (w_last) n_state = ST_DONE;
                else        n_state = w_key_hit ? ST_CRD : ST_SRD;
            end
            ST_CRD:  n_state = ST_CCMP;
            ST_CCMP: n_state = w_last ? ST_DONE : ST_CRD;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        w_adv      = 1'b0;
        w_mem_we   = 1'b0;
        w_wr_addr  = w_slot;
        w_wdata    = '{home: r_home, key: r_key};
        w_set_en   = 1'b0;
        w_clr_en   = 1'b0;
        w_clr_addr = w_slot;
        w_hole_ld  = 1'b0;
        w_hole_nx  = r_hole;
        w_succ_ld  = 1'b0;
        w_succ_val = 1'b0;
        case (r_state)
            ST_INS: begin
                if (!w_s_valid) begin
                    w_mem_we   = 1'b1;
                    w_set_en   = 1'b1;
                    w_succ_ld  = 1'b1;
                    w_succ_val = 1'b1;
                end else if (w_last) begin
                    w_succ_ld  = 1'b1;
                end else begin
                    w_adv      = 1'b1;
                end
            end
            ST_DCHK: begin
                if (!w_s_valid) w_succ_ld = 1'b1;
            end
            ST_SCMP: begin
                if (w_key_hit) begin
                    w_hole_ld = 1'b1;
                    w_hole_nx = w_slot;
                    if (w_last) begin
                        w_clr_en   = 1'b1;
                        w_succ_ld  = 1'b1;
                        w_succ_val = 1'b1;
                    end else begin
                        w_adv      = 1'b1;
                    end
                end else if (w_last) begin
                    w_succ_ld = 1'b1;
                end else begin
                    w_adv     = 1'b1;
                end
            end
            ST_CCMP: begin
                // same-home entry moves back into the hole
                if (w_home_hit) begin
                    w_mem_we  = 1'b1;
                    w_wr_addr = r_hole;
                    w_wdata   = r_rd_data;
                    w_hole_ld = 1'b1;
                    w_hole_nx = w_slot;
                end
                if (w_last) begin
                    w_clr_en   = 1'b1;
                    w_clr_addr = w_hole_nx;
                    w_succ_ld  = 1'b1;
                    w_succ_val = 1'b1;
                end else begin
                    w_adv      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_set_en) r_slot_valid[w_slot]     <= 1'b1;
            if (w_clr_en) r_slot_valid[w_clr_addr] <= 1'b0;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and sequencer counters
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op   <= i_req.op;
            r_key  <= i_req.key;
            r_step <= 1'b0;
        end else if (r_state == ST_HOME) begin
            if (!r_step) r_quot <= w_prod[PROD_W-1:RECIP_SH];
            else         r_home <= w_rem[HOME_W-1:0];
            r_step <= 1'b1;
        end

        if (r_state == ST_HOME) begin
            r_j  <= '0;
            r_sq <= '0;
        end else if (w_adv) begin
            r_j  <= r_j + 1'b1;
            r_sq <= w_sq_nx;
        end

        if (w_hole_ld) r_hole <= w_hole_nx;
        if (w_succ_ld) r_succ <= w_succ_val;
        if (r_state == ST_DONE && w_out_free) r_out_success <= r_succ;
    end

    // key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_wr_addr] <= w_wdata;
        r_rd_data <= r_mem[w_slot];
    end

    a_ins_fills_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_set_en |=> $countones(r_slot_valid) == $past($countones(r_slot_valid)) + 1)
        else $error("insert did not occupy exactly one new slot");

    a_del_frees_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_en |=> $countones(r_slot_valid) == $past($countones(r_slot_valid)) - 1)
        else $error("delete did not free exactly one slot");

    a_occupancy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_set_en && !w_clr_en) |=> $stable(r_slot_valid))
        else $error("slot occupancy changed without a set or clear");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |-> (r_j < J_W'(J_LAST)))
        else $error("probe offset advanced past the end of the path");

    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> o_rsp.valid)
        else $error("finished word not presented on the output");

endmodule

/* tb/sv/tb_quadratic_probe_hash_table.sv */
// Testbench: directed and random insert/delete words checked against a hash table predictor
module tb_quadratic_probe_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    import qpht_pkg::*;

    localparam int RAND_WORDS   = 1500;
    localparam int IDLE_PCT     = 21;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int N_DIRECTED   = 20;

    typedef struct packed {
        t_op  op;
        t_key key;
        logic typed;   // expected success given in the row
        logic want;
    } t_row;

    // hand-built sequence: empty home, fills, full path, compaction walks, duplicates
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{OP_DELETE, 31'd0,          1'b1, 1'b0},  // empty table
        '{OP_INSERT, 31'd0,          1'b1, 1'b1},
        '{OP_INSERT, 31'h7FFF_FFFF,  1'b1, 1'b1},
        '{OP_DELETE, 31'd7,          1'b1, 1'b0},  // home taken, key absent
        '{OP_INSERT, 31'd5,          1'b0, 1'b0},
        '{OP_INSERT, 31'd10,         1'b0, 1'b0},
        '{OP_INSERT, 31'd15,         1'b0, 1'b0},
        '{OP_INSERT, 31'd20,         1'b1, 1'b0},  // every slot on path 0 taken
        '{OP_INSERT, 31'd9,          1'b0, 1'b0},
        '{OP_DELETE, 31'd0,          1'b0, 1'b0},  // long compaction with revisits
        '{OP_DELETE, 31'd10,         1'b1, 1'b0},  // stored, but home slot now empty
        '{OP_DELETE, 31'd9,          1'b0, 1'b0},
        '{OP_INSERT, 31'h7FFF_FFFE,  1'b0, 1'b0},
        '{OP_INSERT, 31'd7,          1'b0, 1'b0},
        '{OP_INSERT, 31'd7,          1'b0, 1'b0},  // duplicate copy
        '{OP_DELETE, 31'd7,          1'b0, 1'b0},
        '{OP_DELETE, 31'h7FFF_FFFF,  1'b0, 1'b0},
        '{OP_DELETE, 31'h7FFF_FFFF,  1'b0, 1'b0},
        '{OP_INSERT, 31'h2AAA_AAAA,  1'b0, 1'b0},
        '{OP_INSERT, 31'h5555_5555,  1'b0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    qpht_req_if req ();
    qpht_rsp_if rsp ();

    quadratic_probe_hash_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    always #5ns i_clk = ~i_clk;

    // predicted table contents
    bit   tbl_valid [SLOTS];
    t_key tbl_key   [SLOTS];

    logic success_q [$];
    int   fail_count   = 0;
    int   quiet_cycles = 0;
    bit   calm         = 1'b0;
    logic rsp_want;

    function automatic int unsigned key_home(t_key k);
        return int'(k % HOME_MOD);
    endfunction

    function automatic int unsigned probe_at(int unsigned home, int unsigned j);
        return (home + j * j) % SLOTS;
    endfunction

    function automatic logic table_insert(t_key k);
        int unsigned home;
        int unsigned s;
        home = key_home(k);
        for (int j = 0; j <= J_LAST; j++) begin
            s = probe_at(home, j);
            if (!tbl_valid[s]) begin
                tbl_valid[s] = 1'b1;
                tbl_key[s]   = k;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic table_delete(t_key k);
        int unsigned home;
        int unsigned s;
        int unsigned hole;
        int          found;
        home  = key_home(k);
        found = -1;
        if (!tbl_valid[probe_at(home, 0)]) return 1'b0;
        for (int j = 0; j <= J_LAST; j++) begin
            s = probe_at(home, j);
            if (tbl_valid[s] && tbl_key[s] == k) begin
                found = j;
                break;
            end
        end
        if (found < 0) return 1'b0;
        // pull later same-home entries back into the hole
        hole = probe_at(home, found);
        for (int j = found + 1; j <= J_LAST; j++) begin
            s = probe_at(home, j);
            if (tbl_valid[s] && key_home(tbl_key[s]) == home) begin
                tbl_key[hole] = tbl_key[s];
                hole          = s;
            end
        end
        tbl_valid[hole] = 1'b0;
        return 1'b1;
    endfunction

    function automatic int occupancy();
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++) n += tbl_valid[s];
        return n;
    endfunction

    function automatic bit pick_stored(output t_key k);
        int unsigned idx [$];
        for (int s = 0; s < SLOTS; s++) begin
            if (tbl_valid[s]) idx.push_back(s);
        end
        if (idx.size() == 0) return 1'b0;
        k = tbl_key[idx[$urandom_range(idx.size() - 1)]];
        return 1'b1;
    endfunction

    // small keys collide and repeat; full-width keys toggle every bit
    function automatic t_key random_key();
        if ($urandom_range(99) < 55) return t_key'($urandom_range(49));
        return t_key'($urandom);
    endfunction

    task automatic send_word(input t_op op, input t_key key, input logic typed,
                             input logic want);
        logic got;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.key   <= key;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        got = (op == OP_INSERT) ? table_insert(key) : table_delete(key);
        success_q.push_back(typed ? want : got);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (success_q.size() != 0) @(posedge i_clk);
    endtask

    // response side: random stalls, compare against oldest expected word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (rsp.valid && rsp.ready) begin
                if (success_q.size() == 0) begin
                    $error("success: no word expected, actual %0b", rsp.success);
                    fail_count++;
                end else begin
                    rsp_want = success_q.pop_front();
                    if (rsp.success !== rsp_want) begin
                        $error("success: expected %0b, actual %0b", rsp_want, rsp.success);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_key key;
        int   used;
        i_rst_n   = 1'b0;
        req.valid = 1'b0;
        req.op    = OP_INSERT;
        req.key   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_word(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].want);
        end
        drain();

        for (int n = 0; n < RAND_WORDS; n++) begin
            calm = (n >= 400 && n < 700);
            if (n == 750) drain();
            used = occupancy();
            if ($urandom_range(99) < (used < 8 ? 65 : 35)) begin
                send_word(OP_INSERT, random_key(), 1'b0, 1'b0);
            end else if ($urandom_range(99) < 80 && pick_stored(key)) begin
                send_word(OP_DELETE, key, 1'b0, 1'b0);
            end else begin
                send_word(OP_DELETE, random_key(), 1'b0, 1'b0);
            end
        end
        calm = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
